>>> src/kcst_pkg.sv
// package for the keyed count and sum table
// holds widths, the command passed from front to back and the state codes
// no dependencies
`default_nettype none

package kcst_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ADDR_W          = 8;   // enough for the largest supported table
    localparam int QUEUE_DEPTH     = 4;

    localparam int KEY_W  = 16;
    localparam int AMT_W  = 32;
    localparam int RIDX_W = 5;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int USED_W = 6;

    localparam int ENTRY_W     = KEY_W + CNT_W + SUM_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    // what the back end has to do with an item
    typedef enum logic [2:0] {
        OP_HIT,     // key found, update entry
        OP_ALLOC,   // new key, fill next free entry
        OP_DROP,    // new key, table full
        OP_READ,    // read of an occupied entry
        OP_MISS     // read of an unoccupied entry
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   addr;
        logic [RIDX_W-1:0]   out_idx;
        logic [KEY_W-1:0]    key;
        logic [AMT_W-1:0]    amount;
        logic [USED_W-1:0]   used;
    } t_cmd;

    typedef enum logic {
        BS_FETCH,
        BS_UPDATE
    } t_bstate;

endpackage

`default_nettype wire

>>> src/keyed_count_and_sum_table.sv
// keyed count and sum table: front end, command queue and back end
// depends on kcst_pkg, kcst_front, kcst_queue and kcst_back
// an item waits in the queue behind any earlier work, then goes through fetch and update
// one command is in fetch or update at a time, for the read-modify-write of the entry memory
// the front end takes items each cycle until the 4-deep command queue fills
// reset clears the occupancy count, queue, back-end state and output valid; entries are not cleared
`default_nettype none

module keyed_count_and_sum_table_core #(
    parameter int TABLE_DEPTH = kcst_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [kcst_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // group_key, amount_cents, read_index
    input  wire                                 i_s_tuser,  // kind
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [kcst_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // entry_index, entry_key, record_count,
                                                            // total_cents, entries_used
    output logic [kcst_pkg::OUT_TUSER_W-1:0]    o_m_tuser   // is_new, dropped, entry_valid
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    kcst_pkg::t_cmd push_cmd;
    kcst_pkg::t_cmd pop_cmd;

    kcst_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_kind    (i_s_tuser),
        .i_key     (i_s_tdata[15:0]),
        .i_amount  (i_s_tdata[47:16]),
        .i_ridx    (i_s_tdata[52:48]),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    kcst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    kcst_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser)
    );

`ifndef SYNTHESIS
    // the back end only takes a command that is there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("back end popped an empty queue");

    // back-to-back allocations fill consecutive entries
    a_alloc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_cmd.op == kcst_pkg::OP_ALLOC) ##1
        (push && push_cmd.op == kcst_pkg::OP_ALLOC)
        |-> push_cmd.addr == $past(push_cmd.addr) + kcst_pkg::ADDR_W'(1))
        else $error("allocation skipped or repeated an entry");

    // a fresh result comes from a command popped in the fetch state ahead of its update
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(pop, 2))
        else $error("result without a popped command");
`endif

endmodule

`default_nettype wire

>>> src/kcst_front.sv
// front end: accepts items, looks the key up among occupied entries, allocates
// new keys while the table has room and issues one command per item; uses kcst_pkg
`default_nettype none

module kcst_front #(
    parameter int TABLE_DEPTH = kcst_pkg::TABLE_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_kind,
    input  wire  [kcst_pkg::KEY_W-1:0]       i_key,
    input  wire  [kcst_pkg::AMT_W-1:0]       i_amount,
    input  wire  [kcst_pkg::RIDX_W-1:0]      i_ridx,
    input  wire                              i_q_ready,
    output logic                             o_push,
    output kcst_pkg::t_cmd                   o_cmd
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UC_W  = $clog2(TABLE_DEPTH + 1);

    logic [kcst_pkg::KEY_W-1:0] r_key [TABLE_DEPTH];
    logic [UC_W-1:0]            r_used;
    logic [UC_W-1:0]            n_used;

    logic [TABLE_DEPTH-1:0]     match;
    logic [IDX_W-1:0]           hit_idx;
    logic                       hit;
    logic                       full;
    logic                       read_ok;
    logic                       alloc;
    logic [IDX_W-1:0]           entry_idx;
    logic [IDX_W+kcst_pkg::ADDR_W-1:0] addr_ext;
    logic [IDX_W+kcst_pkg::RIDX_W-1:0] oidx_ext;
    logic [UC_W+kcst_pkg::USED_W-1:0]  used_ext;

    // keys of occupied entries are unique, so the hit index is a plain or
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match[i] = (UC_W'(i) < r_used) && (r_key[i] == i_key);
            if (match[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit     = |match;
    assign full    = (r_used == UC_W'(TABLE_DEPTH));
    assign read_ok = {{UC_W{1'b0}}, i_ridx} < {{kcst_pkg::RIDX_W{1'b0}}, r_used};
    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign alloc   = o_push && !i_kind && !hit && !full;
    assign n_used  = alloc ? r_used + UC_W'(1) : r_used;

    assign entry_idx = hit ? hit_idx : r_used[IDX_W-1:0];
    assign addr_ext  = {{kcst_pkg::ADDR_W{1'b0}}, entry_idx};
    assign oidx_ext  = {{kcst_pkg::RIDX_W{1'b0}}, entry_idx};
    assign used_ext  = {{kcst_pkg::USED_W{1'b0}}, n_used};

    always_comb begin
        o_cmd.key    = i_key;
        o_cmd.amount = i_amount;
        o_cmd.used   = used_ext[kcst_pkg::USED_W-1:0];
        if (i_kind) begin
            o_cmd.op      = read_ok ? kcst_pkg::OP_READ : kcst_pkg::OP_MISS;
            o_cmd.addr    = {{(kcst_pkg::ADDR_W - kcst_pkg::RIDX_W){1'b0}}, i_ridx};
            o_cmd.out_idx = i_ridx;
        end else if (!hit && full) begin
            o_cmd.op      = kcst_pkg::OP_DROP;
            o_cmd.addr    = '0;
            o_cmd.out_idx = '0;
        end else begin
            o_cmd.op      = hit ? kcst_pkg::OP_HIT : kcst_pkg::OP_ALLOC;
            o_cmd.addr    = addr_ext[kcst_pkg::ADDR_W-1:0];
            o_cmd.out_idx = oidx_ext[kcst_pkg::RIDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_key[r_used[IDX_W-1:0]] <= i_key;
        end
    end

endmodule

`default_nettype wire

>>> src/kcst_queue.sv
// short command queue between front and back end
// uses kcst_pkg for the command type and its depth
`default_nettype none

module kcst_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  kcst_pkg::t_cmd      i_cmd,
    output logic                o_ready,
    input  wire                 i_pop,
    output logic                o_valid,
    output kcst_pkg::t_cmd      o_cmd
);

    localparam int DEPTH = kcst_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FC_W  = $clog2(DEPTH + 1);

    kcst_pkg::t_cmd   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [FC_W-1:0]  r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_fill != FC_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + FC_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - FC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/kcst_back.sv
// back end: entry memory with key, count and total, read, update or fill
// of an entry per command, and the output register; uses kcst_pkg
`default_nettype none

module kcst_back #(
    parameter int TABLE_DEPTH = kcst_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_q_valid,
    input  kcst_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [kcst_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [kcst_pkg::OUT_TUSER_W-1:0]    o_tuser
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW    = kcst_pkg::KEY_W;
    localparam int CW    = kcst_pkg::CNT_W;
    localparam int SW    = kcst_pkg::SUM_W;
    localparam int EW    = kcst_pkg::ENTRY_W;

    logic [EW-1:0]            r_mem [TABLE_DEPTH];
    logic [EW-1:0]            r_rd;
    kcst_pkg::t_cmd           r_cmd;
    kcst_pkg::t_bstate        r_state;
    kcst_pkg::t_bstate        n_state;

    logic                     r_out_valid;
    logic [kcst_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [kcst_pkg::OUT_TUSER_W-1:0] r_out_user;
    logic [kcst_pkg::OUT_TDATA_W-1:0] n_out_data;
    logic [kcst_pkg::OUT_TUSER_W-1:0] n_out_user;

    logic                     rd_en;
    logic                     wr_en;
    logic                     load;
    logic [EW-1:0]            wr_data;

    logic [KW-1:0]            rd_key;
    logic [CW-1:0]            rd_cnt;
    logic [SW-1:0]            rd_sum;
    logic [SW:0]              sum_wide;
    logic [CW-1:0]            new_cnt;
    logic [SW-1:0]            new_sum;

    logic [KW-1:0]            o_key;
    logic [CW-1:0]            o_cnt;
    logic [SW-1:0]            o_sum;
    logic                     o_new;
    logic                     o_drop;
    logic                     o_ok;

    assign rd_key = r_rd[EW-1 -: KW];
    assign rd_cnt = r_rd[SW +: CW];
    assign rd_sum = r_rd[SW-1:0];

    assign sum_wide = {1'b0, rd_sum} + {{(SW + 1 - kcst_pkg::AMT_W){1'b0}}, r_cmd.amount};
    assign new_sum  = sum_wide[SW] ? kcst_pkg::SUM_MAX : sum_wide[SW-1:0];
    assign new_cnt  = (rd_cnt == kcst_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + CW'(1);

    // fetch reads the entry, update writes it back once the output register is free
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            kcst_pkg::BS_FETCH: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = kcst_pkg::BS_UPDATE;
                end
            end
            kcst_pkg::BS_UPDATE: begin
                if (!r_out_valid || i_ready) begin
                    load    = 1'b1;
                    n_state = kcst_pkg::BS_FETCH;
                end
            end
            default: begin
                n_state = kcst_pkg::BS_FETCH;
            end
        endcase
    end

    assign rd_en = o_pop && (i_cmd.op == kcst_pkg::OP_HIT || i_cmd.op == kcst_pkg::OP_READ);

    always_comb begin
        o_key   = '0;
        o_cnt   = '0;
        o_sum   = '0;
        o_new   = 1'b0;
        o_drop  = 1'b0;
        o_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_data = {r_cmd.key, new_cnt, new_sum};
        unique case (r_cmd.op)
            kcst_pkg::OP_HIT: begin
                wr_en = load;
                o_key = r_cmd.key;
                o_cnt = new_cnt;
                o_sum = new_sum;
                o_ok  = 1'b1;
            end
            kcst_pkg::OP_ALLOC: begin
                wr_en   = load;
                wr_data = {r_cmd.key, CW'(1), {(SW - kcst_pkg::AMT_W){1'b0}}, r_cmd.amount};
                o_key   = r_cmd.key;
                o_cnt   = CW'(1);
                o_sum   = {{(SW - kcst_pkg::AMT_W){1'b0}}, r_cmd.amount};
                o_new   = 1'b1;
                o_ok    = 1'b1;
            end
            kcst_pkg::OP_READ: begin
                o_key = rd_key;
                o_cnt = rd_cnt;
                o_sum = rd_sum;
                o_ok  = 1'b1;
            end
            kcst_pkg::OP_DROP: begin
                o_drop = 1'b1;
            end
            default: begin
                o_ok = 1'b0;
            end
        endcase
        n_out_data = {5'b0, r_cmd.used, o_sum, o_cnt, o_key, r_cmd.out_idx};
        n_out_user = {o_ok, o_drop, o_new};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcst_pkg::BS_FETCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[i_cmd.addr[IDX_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_cmd.addr[IDX_W-1:0]] <= wr_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tdata = r_out_data;
    assign o_tuser = r_out_user;

endmodule

`default_nettype wire
